// ----- src/gsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the generational slot allocator
// Holds the slot count, field widths, request and failure codes, and the
// structs that pass between the slot map and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

  // Pool size and derived index width
  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  // Field widths
  localparam int REQ_W = 2;
  localparam int HIDX_W = 16;
  localparam int GEN_W  = 16;
  localparam int CAUSE_W = 3;

  localparam logic [HIDX_W-1:0] SLOT_COUNT = HIDX_W'(NUM_SLOTS);
  localparam logic [HIDX_W-1:0] NO_INDEX   = '1;

  // Request codes; the unused code behaves as a check
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  // Failure causes
  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE  = 3'd0,
    CAUSE_FULL  = 3'd1,
    CAUSE_RANGE = 3'd2,
    CAUSE_FREE  = 3'd3,
    CAUSE_STALE = 3'd4
  } cause_t;

  // Occupancy update toward the slot map
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } slot_upd_t;

  // Lowest free slot reported by the slot map
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_info_t;

endpackage

`default_nettype wire

// ----- src/gsa_slot_map.sv -----
// ----------------------------------------------------------------------------
// gsa_slot_map: occupancy bitmap with lowest-free-slot encoder
// Keeps one busy flop per slot, reports the lowest free slot and the busy
// flag of one probed slot, and applies set and clear updates.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_slot_map
  import gsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire slot_upd_t        upd,
  input  wire logic [IDX_W-1:0] probe_idx,
  output logic                  probe_busy,
  output free_info_t            free_slot
);

  logic [NUM_SLOTS-1:0] busy_r;

  // Update occupancy; reset frees every slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      if (upd.set) begin
        busy_r[upd.idx] <= 1'b1;
      end
      if (upd.clr) begin
        busy_r[upd.idx] <= 1'b0;
      end
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_slot.found = 1'b1;
        free_slot.idx   = IDX_W'(i);
      end
    end
  end

  assign probe_busy = busy_r[probe_idx];

endmodule

`default_nettype wire

// ----- src/gsa_gen_mem.sv -----
// ----------------------------------------------------------------------------
// gsa_gen_mem: generation count memory
// One write port and one registered read port. Entries never written since
// reset read as zero through a per-entry written flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_gen_mem
  import gsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [GEN_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [GEN_W-1:0] wr_data
);

  logic [GEN_W-1:0]     mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written_r;
  logic [GEN_W-1:0]     rd_q_r;
  logic                 rd_valid_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; reset marks all as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= written_r[rd_addr];
      end
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ----- src/generational_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_slot_allocator: handle allocator over a fixed slot pool
// Allocates the lowest free slot, frees and checks generation-tagged handles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_tuser carries the request kind (allocate, free,
//   check), in_tdata the handle index and generation. Output channel out_*:
//   out_tuser is the success flag, out_tdata holds index, generation and
//   failure cause. Every item yields exactly one result item.
//   The generation memory is read at the accepting edge; the request then
//   resolves and writes back while its result is loaded into the output
//   register.
//   No new item is taken until the current one has resolved, for the
//   generation memory read, its write-back and the bitmap update.
//   A finished result waits in the output register while the next item is
//   taken; if the receiver still stalls when that next item resolves, the
//   block holds it and takes no further item until the register drains.
//   Reset (synchronous, active low) frees all slots and zeroes every
//   generation at once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] handle_index, [31:16] handle_generation
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] out_index, [31:16] out_generation,
                                       // [34:32] fail_cause, [39:35] zero
  output logic [0:0]       out_tuser   // [0] ok
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r;

  // Request captured at accept
  logic [REQ_W-1:0]  req_r;
  logic [HIDX_W-1:0] hidx_r;
  logic [GEN_W-1:0]  hgen_r;
  logic              range_bad_r;
  free_info_t        alloc_r;

  // Output register
  logic              out_valid_r;
  logic [HIDX_W-1:0] out_index_r;
  logic [GEN_W-1:0]  out_gen_r;
  cause_t            out_cause_r;
  logic              out_ok_r;

  logic              in_fire;
  logic              exec_fire;
  logic [HIDX_W-1:0] in_hidx;
  logic [GEN_W-1:0]  in_hgen;
  logic [IDX_W-1:0]  rd_addr;
  logic [GEN_W-1:0]  rd_gen;
  logic              probe_busy;
  free_info_t        free_slot;
  slot_upd_t         upd;
  cause_t            chk_cause;
  logic              gen_wr_en;
  logic [GEN_W-1:0]  gen_wr_data;

  assign in_hidx   = in_tdata[15:0];
  assign in_hgen   = in_tdata[31:16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // Address the memory with the slot to allocate or the handle's slot
  assign rd_addr = (in_tuser == REQ_ALLOC) ? free_slot.idx : in_hidx[IDX_W-1:0];

  gsa_slot_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .probe_idx  (hidx_r[IDX_W-1:0]),
    .probe_busy (probe_busy),
    .free_slot  (free_slot)
  );

  gsa_gen_mem u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_gen),
    .wr_en   (gen_wr_en),
    .wr_addr (hidx_r[IDX_W-1:0]),
    .wr_data (gen_wr_data)
  );

  // Resolve handle checks in order: range, occupancy, generation
  always_comb begin
    priority if (range_bad_r) begin
      chk_cause = CAUSE_RANGE;
    end else if (!probe_busy) begin
      chk_cause = CAUSE_FREE;
    end else if (rd_gen != hgen_r) begin
      chk_cause = CAUSE_STALE;
    end else begin
      chk_cause = CAUSE_NONE;
    end
  end

  // Write back slot state when the request resolves
  always_comb begin
    upd         = '0;
    gen_wr_en   = 1'b0;
    gen_wr_data = rd_gen + GEN_W'(1);
    if (exec_fire) begin
      if (req_r == REQ_ALLOC) begin
        upd.set = alloc_r.found;
        upd.idx = alloc_r.idx;
      end else if (req_r == REQ_FREE && chk_cause == CAUSE_NONE) begin
        upd.clr   = 1'b1;
        upd.idx   = hidx_r[IDX_W-1:0];
        gen_wr_en = 1'b1;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r       <= in_tuser;
      hidx_r      <= in_hidx;
      hgen_r      <= in_hgen;
      range_bad_r <= (in_hidx >= SLOT_COUNT);
      alloc_r     <= free_slot;
    end
  end

  // Sequence requests and hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drain the output register unless a new result lands in it
      if (out_valid_r && out_tready && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            if (req_r == REQ_ALLOC) begin
              out_ok_r    <= alloc_r.found;
              out_index_r <= alloc_r.found ? HIDX_W'(alloc_r.idx) : NO_INDEX;
              out_gen_r   <= alloc_r.found ? rd_gen : '0;
              out_cause_r <= alloc_r.found ? CAUSE_NONE : CAUSE_FULL;
            end else begin
              out_ok_r    <= (chk_cause == CAUSE_NONE);
              out_index_r <= '0;
              out_gen_r   <= '0;
              out_cause_r <= chk_cause;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cause_r, out_gen_r, out_index_r};
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire

// ----- src/gsa_checker.sv -----
// ----------------------------------------------------------------------------
// gsa_checker: port-level checks for the generational slot allocator
// Watches the stream ports for result consistency and request pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_checker
  import gsa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Items are never taken back to back
  a_in_pace: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken in back-to-back cycles");

  // Success flag agrees with an empty failure cause
  a_ok_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[34:32] == CAUSE_NONE)))
    else $error("ok flag and fail cause disagree");

  // Pool full returns the invalid handle
  a_full_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] == CAUSE_FULL
      |-> out_tdata[15:0] == NO_INDEX && out_tdata[31:16] == '0)
    else $error("pool full without invalid handle");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the generational slot allocator
// Streams allocate, free and check requests into the allocator and predicts
// every result from a shadow copy of the occupancy flags and generations.
// Each returned item is compared field by field with the oldest prediction.
// The run covers a short directed sequence and random phases with varying
// allocate pressure.
// Random gaps are placed on both the request side and the result side.
// ----------------------------------------------------------------------------

module tb_top;
  import gsa_pkg::*;

  // Unused request code; the allocator treats it as a check
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS  = 30;
  localparam int PHASES      = 11;
  localparam int PHASE_LEN   = 150;

  // One request waiting to be driven
  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
    bit                may_idle;
    bit                drain_first;
  } slot_req_t;

  // One predicted result
  typedef struct packed {
    logic              ok;
    logic [HIDX_W-1:0] index;
    logic [GEN_W-1:0]  generation;
    cause_t            cause;
  } slot_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;

  // Shadow state of the slot pool
  logic             slot_taken [NUM_SLOTS];
  logic [GEN_W-1:0] slot_gen_now [NUM_SLOTS];

  slot_req_t    pending_reqs [$];
  slot_result_t expected_results [$];

  slot_req_t    cur_req;
  slot_result_t want;
  int           src_gap = 0;
  int           sink_gap = 0;
  bit           sink_idle_en = 1'b1;
  int           stall_cycles = 0;
  int           error_count = 0;
  int           accepted_count = 0;
  int           results_checked = 0;
  int           cause_hits [5] = '{0, 0, 0, 0, 0};

  generational_slot_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Print one mismatch line (capped) and count it
  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS) begin
      $display("MISMATCH at result %0d: %s", results_checked, what);
    end
    error_count++;
  endtask

  // Serve one request against the shadow pool and return its result
  function automatic slot_result_t serve_request(input logic [REQ_W-1:0] kind,
                                                 input logic [HIDX_W-1:0] idx,
                                                 input logic [GEN_W-1:0] gen);
    slot_result_t res;
    int           s;
    res = '{ok: 1'b0, index: '0, generation: '0, cause: CAUSE_NONE};
    if (kind == REQ_ALLOC) begin
      res.index = NO_INDEX;
      res.cause = CAUSE_FULL;
      // take the lowest free slot
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (!slot_taken[s] && res.cause == CAUSE_FULL) begin
          slot_taken[s]  = 1'b1;
          res.ok         = 1'b1;
          res.index      = HIDX_W'(s);
          res.generation = slot_gen_now[s];
          res.cause      = CAUSE_NONE;
        end
      end
    end else begin
      // range first, then occupancy, then generation
      if (idx >= SLOT_COUNT) begin
        res.cause = CAUSE_RANGE;
      end else if (!slot_taken[idx]) begin
        res.cause = CAUSE_FREE;
      end else if (slot_gen_now[idx] != gen) begin
        res.cause = CAUSE_STALE;
      end
      if (kind == REQ_FREE && res.cause == CAUSE_NONE) begin
        slot_taken[idx]   = 1'b0;
        slot_gen_now[idx] = slot_gen_now[idx] + 1'b1;
      end
      res.ok = (res.cause == CAUSE_NONE);
    end
    return res;
  endfunction

  // Request driver: predict on acceptance, then load the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_taken[s]   = 1'b0;
        slot_gen_now[s] = '0;
      end
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(serve_request(in_tuser, in_tdata[15:0], in_tdata[31:16]));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap   <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_results.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (pending_reqs[0].may_idle && $urandom_range(0, 9) == 0) begin
          src_gap   <= $urandom_range(0, 12);
          in_tvalid <= 1'b0;
        end else begin
          cur_req      = pending_reqs.pop_front();
          in_tvalid    <= 1'b1;
          in_tdata     <= {cur_req.gen, cur_req.idx};
          in_tuser     <= cur_req.kind;
          sink_idle_en <= cur_req.may_idle;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, then stall or not
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no prediction pending");
        end else begin
          want = expected_results.pop_front();
          cause_hits[want.cause]++;
          if (out_tuser[0] !== want.ok)
            report_mismatch($sformatf("ok got %0b want %0b", out_tuser[0], want.ok));
          if (out_tdata[15:0] !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", out_tdata[15:0], want.index));
          if (out_tdata[31:16] !== want.generation)
            report_mismatch($sformatf("generation got %0d want %0d",
                                      out_tdata[31:16], want.generation));
          if (out_tdata[34:32] !== want.cause)
            report_mismatch($sformatf("cause got %0d want %0d", out_tdata[34:32], want.cause));
        end
        results_checked++;
      end
      if (sink_gap != 0) begin
        sink_gap   <= sink_gap - 1;
        out_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
        sink_gap   <= $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Add one request, holding back while the queue is full
  task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [HIDX_W-1:0] idx,
                               input logic [GEN_W-1:0] gen, input bit may_idle,
                               input bit drain_first);
    slot_req_t req;
    while (pending_reqs.size() >= 2) @(posedge clk);
    req.kind        = kind;
    req.idx         = idx;
    req.gen         = gen;
    req.may_idle    = may_idle;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  initial begin
    int               alloc_pct [8];
    int               ph;
    int               n;
    int               pick;
    bit               quiet;
    logic [REQ_W-1:0]  kind;
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  g;

    alloc_pct = '{95, 70, 40, 15, 55, 85, 30, 50};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: range, free slot, stale handle, spare code, reuse of freed slots
    queue_request(REQ_CHECK, 16'd0,     16'd0,     1'b1, 1'b1);
    queue_request(REQ_CHECK, SLOT_COUNT, 16'd0,    1'b1, 1'b0);
    queue_request(REQ_FREE,  NO_INDEX,  16'hFFFF,  1'b1, 1'b0);
    queue_request(REQ_FREE,  16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_ALLOC, NO_INDEX,  16'hFFFF,  1'b1, 1'b0);
    queue_request(REQ_ALLOC, 16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_CHECK, 16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_CHECK, 16'd0,     16'hFFFF,  1'b1, 1'b0);
    queue_request(REQ_SPARE, 16'd1,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_SPARE, 16'd1,     16'd1,     1'b1, 1'b0);
    queue_request(REQ_FREE,  16'd0,     16'd1,     1'b1, 1'b0);
    queue_request(REQ_FREE,  16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_FREE,  16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_CHECK, 16'd63,    16'd0,     1'b1, 1'b0);
    queue_request(REQ_ALLOC, 16'd0,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_FREE,  16'd1,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_CHECK, 16'd1,     16'd0,     1'b1, 1'b0);
    queue_request(REQ_ALLOC, 16'd0,     16'd0,     1'b1, 1'b0);

    // Random phases with varying allocate pressure; each starts from a drained pipe
    for (ph = 0; ph < PHASES; ph++) begin
      quiet = (ph >= PHASES - 2);
      for (n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct[ph % 8]) begin
          kind = REQ_ALLOC;
        end else begin
          pick = $urandom_range(0, 19);
          kind = (pick < 11) ? REQ_FREE : (pick < 18) ? REQ_CHECK : REQ_SPARE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 88)
          idx = HIDX_W'($urandom_range(0, NUM_SLOTS - 1));
        else if (pick < 94)
          idx = HIDX_W'($urandom_range(NUM_SLOTS, 65535));
        else
          idx = (pick < 97) ? SLOT_COUNT : NO_INDEX;
        // mostly the live generation, sometimes off by one or random
        pick = $urandom_range(0, 99);
        if (idx < SLOT_COUNT && pick < 75)
          g = slot_gen_now[idx];
        else if (idx < SLOT_COUNT && pick < 85)
          g = $urandom_range(0, 1) ? slot_gen_now[idx] + 1'b1 : slot_gen_now[idx] - 1'b1;
        else
          g = GEN_W'($urandom_range(0, 65535));
        queue_request(kind, idx, g, !quiet, n == 0);
      end
    end

    // Drain, then keep running to catch any stray result
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests and %0d results over directed and random phases",
             accepted_count, results_checked);
    $display("outcomes: ok %0d, pool full %0d, out of range %0d, slot free %0d, stale %0d",
             cause_hits[CAUSE_NONE], cause_hits[CAUSE_FULL], cause_hits[CAUSE_RANGE],
             cause_hits[CAUSE_FREE], cause_hits[CAUSE_STALE]);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/gsa_pkg.sv
src/gsa_slot_map.sv
src/gsa_gen_mem.sv
src/generational_slot_allocator.sv
src/gsa_checker.sv
tb/tb_top.sv
